[rtl/core/itar_pkg.sv]
package itar_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_DIGITS = 32;

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS = 8;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX = 6'd9;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FETCH,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fetch;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic more;
    logic sign_pending;
    logic idx_zero;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_DEC_MAX) begin
      c = CHAR_A + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

[rtl/core/itar_ram.sv]
module itar_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/itar_dp.sv]
module itar_dp #(
  parameter int VALUE_BITS = itar_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = itar_pkg::DEF_MAX_DIGITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  itar_pkg::cmd_t                     cmd,
  output itar_pkg::sts_t                     sts,
  input  logic signed [VALUE_BITS-1:0]       value,
  input  logic [itar_pkg::RADIX_W-1:0]       radix,
  output logic                               strobe,
  output logic [itar_pkg::CHAR_W-1:0]        character,
  output logic                               last
);

  localparam int STEPS    = (VALUE_BITS + itar_pkg::DIV_BITS - 1) / itar_pkg::DIV_BITS;
  localparam int PAD_BITS = STEPS * itar_pkg::DIV_BITS;
  localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W   = $clog2(MAX_DIGITS);
  localparam int DW       = itar_pkg::DIGIT_W;

  logic [PAD_BITS-1:0]          quot;
  logic [PAD_BITS-1:0]          quot_next;
  logic [DW-1:0]                rem;
  logic [itar_pkg::RADIX_W-1:0] radix_r;
  logic [itar_pkg::RADIX_W-1:0] radix_clamp;
  logic [STEP_W-1:0]            step;
  logic [CNT_W-1:0]             count;
  logic [CNT_W:0]               cnt_inc;
  logic [ADDR_W-1:0]            idx;
  logic                         neg;
  logic                         neg_in;
  logic [VALUE_BITS-1:0]        mag;
  logic [itar_pkg::DIV_BITS-1:0] qbits;
  logic [DW-1:0]                r_acc;
  logic [DW:0]                  trial;
  logic [ADDR_W-1:0]            cnt_m1;
  logic [ADDR_W-1:0]            idx_m1;
  logic [ADDR_W-1:0]            raddr;
  logic                         ram_re;
  logic                         ram_we;
  logic [DW-1:0]                rdata;

  // clamp the radix and fold a negative decimal value into its magnitude
  always_comb begin
    priority if (radix < itar_pkg::RADIX_MIN) begin
      radix_clamp = itar_pkg::RADIX_MIN;
    end else if (radix > itar_pkg::RADIX_MAX) begin
      radix_clamp = itar_pkg::RADIX_MAX;
    end else begin
      radix_clamp = radix;
    end
    neg_in = (radix_clamp == itar_pkg::RADIX_DEC) && value[VALUE_BITS-1];
    mag    = neg_in ? (~$unsigned(value) + 1'b1) : $unsigned(value);
  end

  // restoring division, DIV_BITS quotient bits per cycle, msb first
  always_comb begin
    r_acc = rem;
    qbits = '0;
    trial = '0;
    for (int i = 0; i < itar_pkg::DIV_BITS; i++) begin
      trial = {r_acc, quot[PAD_BITS-1-i]};
      if (trial >= {1'b0, radix_r}) begin
        r_acc = DW'(trial - {1'b0, radix_r});
        qbits[itar_pkg::DIV_BITS-1-i] = 1'b1;
      end else begin
        r_acc = trial[DW-1:0];
      end
    end
    quot_next = (quot << itar_pkg::DIV_BITS) | PAD_BITS'(qbits);
  end

  assign cnt_inc = {1'b0, count} + 1'b1;
  assign cnt_m1  = ADDR_W'(count - 1'b1);
  assign idx_m1  = idx - 1'b1;

  assign sts.step_last    = (step == STEP_W'(STEPS - 1));
  assign sts.more         = (quot_next != '0) && (cnt_inc < (CNT_W + 1)'(MAX_DIGITS));
  assign sts.sign_pending = neg && (count < CNT_W'(MAX_DIGITS));
  assign sts.idx_zero     = (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem     <= '0;
      radix_r <= itar_pkg::RADIX_MIN;
      step    <= '0;
      count   <= '0;
      neg     <= 1'b0;
    end else if (cmd.load) begin
      rem     <= '0;
      radix_r <= radix_clamp;
      step    <= '0;
      count   <= '0;
      neg     <= neg_in;
    end else if (cmd.div_step) begin
      if (sts.step_last) begin
        rem   <= '0;
        step  <= '0;
        count <= CNT_W'(cnt_inc);
      end else begin
        rem  <= r_acc;
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot <= PAD_BITS'(mag);
    end else if (cmd.div_step) begin
      quot <= quot_next;
    end
    if (cmd.fetch) begin
      idx <= cnt_m1;
    end else if (cmd.emit_digit) begin
      idx <= idx_m1;
    end
  end

  assign ram_we = cmd.div_step && sts.step_last;
  assign ram_re = cmd.fetch || cmd.emit_digit;
  assign raddr  = cmd.fetch ? cnt_m1 : idx_m1;

  itar_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (r_acc),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= itar_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= itar_pkg::digit_char(rdata);
      last      <= sts.idx_zero;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond buffer depth");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    rem < radix_r)
    else $error("partial remainder not below radix");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (count == '0) && (step == '0) && (rem == '0))
    else $error("conversion did not start from a clean state");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("character issued right after the final one");

endmodule

[rtl/core/itar_ctrl.sv]
module itar_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  itar_pkg::sts_t sts,
  output itar_pkg::cmd_t cmd,
  output logic           busy
);

  itar_pkg::state_t state;
  itar_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      itar_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = itar_pkg::ST_DIVIDE;
        end
      end
      itar_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        // keep dividing until the quotient runs out or the buffer fills
        if (sts.step_last && !sts.more) begin
          state_next = itar_pkg::ST_FETCH;
        end
      end
      itar_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = sts.sign_pending ? itar_pkg::ST_SIGN : itar_pkg::ST_EMIT;
      end
      itar_pkg::ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = itar_pkg::ST_EMIT;
      end
      itar_pkg::ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (sts.idx_zero) begin
          state_next = itar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = itar_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/integer_to_ascii_radix_core.sv]
// Integer to ASCII text in a radix from 2 to 36.
// Request channel: drive value and radix and raise start; the request is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the last character has been issued.
// Result channel: one character per strobe cycle, most significant first,
// with last set on the final character. Digits above nine are 'a' to 'z'.
// Radix 10 with a negative value gives a leading '-'; any other radix reads
// the bit pattern as unsigned. Radix below 2 acts as 2, above 36 as 36.
// Each digit takes a full pass of the shared remainder divider over the
// running quotient, which resolves 8 quotient bits per cycle. Characters
// leave one per cycle from a registered read of the digit buffer.
// The receiver cannot stall: each strobe lasts exactly one cycle.
// Reset returns the controller to idle and drops strobe; no clearing pass.
module integer_to_ascii_radix_core #(
  parameter int VALUE_BITS = itar_pkg::DEF_VALUE_BITS,
  parameter int MAX_DIGITS = itar_pkg::DEF_MAX_DIGITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [itar_pkg::RADIX_W-1:0] radix,
  output logic                         strobe,
  output logic [itar_pkg::CHAR_W-1:0]  character,
  output logic                         last
);

  itar_pkg::cmd_t cmd;
  itar_pkg::sts_t sts;

  itar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  itar_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .radix     (radix),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

[test/integer_to_ascii_radix_core_test.sv]
`timescale 1ns / 1ps

module integer_to_ascii_radix_core_test;

  localparam int VALUE_BITS   = itar_pkg::DEF_VALUE_BITS;
  localparam int MAX_DIGITS   = itar_pkg::DEF_MAX_DIGITS;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [VALUE_BITS-1:0] INT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] INT_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef struct packed {
    logic [itar_pkg::CHAR_W-1:0] character;
    logic                        last;
  } text_char_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic signed [VALUE_BITS-1:0] value;
  logic [itar_pkg::RADIX_W-1:0] radix;
  logic                         strobe;
  logic [itar_pkg::CHAR_W-1:0]  character;
  logic                         last;

  text_char_t pending_text[$];
  int         error_count;
  int         stall_cycles;
  int         sender_idle_pct;

  integer_to_ascii_radix_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .radix     (radix),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append the characters a request should produce, most significant first.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] val,
                                       input logic [itar_pkg::RADIX_W-1:0] rad);
    logic [VALUE_BITS-1:0]        base;
    logic [VALUE_BITS-1:0]        magnitude;
    logic                         negative;
    logic [itar_pkg::DIGIT_W-1:0] digits[$];
    logic [itar_pkg::DIGIT_W-1:0] d;
    text_char_t                   tc;
    int                           i;
    if (rad < itar_pkg::RADIX_MIN) begin
      base = VALUE_BITS'(itar_pkg::RADIX_MIN);
    end else if (rad > itar_pkg::RADIX_MAX) begin
      base = VALUE_BITS'(itar_pkg::RADIX_MAX);
    end else begin
      base = VALUE_BITS'(rad);
    end
    negative = (base == VALUE_BITS'(itar_pkg::RADIX_DEC)) && val[VALUE_BITS-1];
    magnitude = negative ? (~val + 1'b1) : val;
    if (magnitude == '0) begin
      digits.push_back('0);
    end else begin
      while (magnitude != '0 && digits.size() < MAX_DIGITS) begin
        digits.push_back(itar_pkg::DIGIT_W'(magnitude % base));
        magnitude = magnitude / base;
      end
    end
    if (negative && digits.size() < MAX_DIGITS) begin
      tc.character = itar_pkg::CHAR_MINUS;
      tc.last = 1'b0;
      pending_text.push_back(tc);
    end
    for (i = digits.size() - 1; i >= 0; i--) begin
      d = digits[i];
      if (d > itar_pkg::DIGIT_DEC_MAX) begin
        tc.character = itar_pkg::CHAR_A +
                       itar_pkg::CHAR_W'(d - itar_pkg::DIGIT_W'(itar_pkg::RADIX_DEC));
      end else begin
        tc.character = itar_pkg::CHAR_ZERO + itar_pkg::CHAR_W'(d);
      end
      tc.last = (i == 0);
      pending_text.push_back(tc);
    end
  endfunction

  // Predict on each accepted request, check each strobed character.
  always @(posedge clk) begin
    text_char_t want;
    logic       moved;
    moved = 1'b0;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (start && !busy) begin
        predict_text(value, radix);
        moved = 1'b1;
      end
      if (strobe) begin
        moved = 1'b1;
        if (pending_text.size() == 0) begin
          $display("%0t: unexpected character %h last %b", $time, character, last);
          error_count++;
        end else begin
          want = pending_text.pop_front();
          if (character !== want.character) begin
            $display("%0t: character expected %h got %h", $time, want.character,
                     character);
            error_count++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, last);
            error_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drive one request and hold it until taken; start stays high afterwards.
  task automatic send_request(input logic [VALUE_BITS-1:0] val,
                              input logic [itar_pkg::RADIX_W-1:0] rad);
    int gap;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(5, 180);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    value = val;
    radix = rad;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_zero_and_small;
    send_request('0, itar_pkg::RADIX_DEC);
    send_request('0, 6'd2);
    send_request('0, itar_pkg::RADIX_MAX);
    send_request(1, 6'd2);
    send_request(9, itar_pkg::RADIX_DEC);
    send_request(10, 6'd11);
    send_request(35, itar_pkg::RADIX_MAX);
    send_request(36, itar_pkg::RADIX_MAX);
  endtask

  task automatic test_signed_extremes;
    send_request('1, itar_pkg::RADIX_DEC);
    send_request(INT_MIN, itar_pkg::RADIX_DEC);
    send_request(INT_MAX, itar_pkg::RADIX_DEC);
    send_request(INT_MIN + 1, itar_pkg::RADIX_DEC);
    send_request('1, 6'd2);
    send_request(INT_MIN, 6'd2);
    send_request(INT_MAX, itar_pkg::RADIX_MAX);
  endtask

  // Outside base ten the bit pattern reads as unsigned.
  task automatic test_negative_non_decimal;
    send_request('1, 6'd16);
    send_request(-12345, 6'd8);
    send_request(-7, itar_pkg::RADIX_MAX);
    send_request(-10, 6'd9);
  endtask

  task automatic test_radix_clamping;
    send_request(255, 6'd0);
    send_request(255, 6'd1);
    send_request(12345, 6'd37);
    send_request('1, 6'd63);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    logic [VALUE_BITS-1:0]        val;
    logic [itar_pkg::RADIX_W-1:0] rad;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      case ($urandom_range(5))
        0: val = $urandom;
        1: val = $urandom_range(0, 40);
        2: val = -$urandom_range(1, 40);
        3: val = {1'b1, (VALUE_BITS-1)'($urandom)};
        4: begin
          case ($urandom_range(4))
            0: val = '0;
            1: val = '1;
            2: val = INT_MIN;
            3: val = INT_MAX;
            default: val = INT_MIN + 1;
          endcase
        end
        default: val = $urandom >> $urandom_range(0, VALUE_BITS - 1);
      endcase
      case ($urandom_range(9))
        0, 1, 2: rad = itar_pkg::RADIX_DEC;
        3: rad = itar_pkg::RADIX_W'($urandom_range(0, 63));
        4: rad = $urandom_range(1) ? 6'd2 : itar_pkg::RADIX_MAX;
        default: rad = itar_pkg::RADIX_W'($urandom_range(itar_pkg::RADIX_MIN,
                                                          itar_pkg::RADIX_MAX));
      endcase
      send_request(val, rad);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    radix = '0;
    error_count = 0;
    stall_cycles = 0;
    sender_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_and_small();
    test_signed_extremes();
    test_negative_non_decimal();
    test_radix_clamping();
    test_random_traffic(100, 0);
    test_random_traffic(105, 47);
    test_random_traffic(100, 0);
    test_random_traffic(105, 32);

    start = 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/itar_pkg.sv
rtl/core/itar_ram.sv
rtl/core/itar_dp.sv
rtl/core/itar_ctrl.sv
rtl/core/integer_to_ascii_radix_core.sv
test/integer_to_ascii_radix_core_test.sv
